[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion wrappers
// clocked on clk; the reset-aware form is disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define PN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pn2d_pkg.sv]
// ----------------------------------------------------------------------------
// pn2d_pkg: shared types and constants for the 2-D gradient noise unit
// field widths of the channels, command codes and output limits
// ----------------------------------------------------------------------------
package pn2d_pkg;

  // fixed payload widths
  localparam int ENTRY_W  = 8;
  localparam int IDX_IN_W = 8;
  localparam int COORD_W  = 32;
  localparam int OUT_W    = 19;

  // output saturation limits
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  // transaction kinds
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

endpackage

[hw/rtl/pn2d_if.sv]
// ----------------------------------------------------------------------------
// pn2d_if: valid/ready channels of the 2-D gradient noise unit
// input channel carries load and evaluate transactions, output carries noise
// ----------------------------------------------------------------------------
interface pn2d_in_if import pn2d_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic        [IDX_IN_W-1:0] table_index;
  logic        [ENTRY_W-1:0]  table_value;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;

  modport source (
    output valid, cmd, table_index, table_value, x_coord, y_coord,
    input  ready
  );
  modport sink (
    input  valid, cmd, table_index, table_value, x_coord, y_coord,
    output ready
  );
endinterface

interface pn2d_out_if import pn2d_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  noise_value;

  modport source (
    output valid, noise_value,
    input  ready
  );
  modport sink (
    input  valid, noise_value,
    output ready
  );
endinterface

[hw/rtl/pn2d_ram.sv]
// ----------------------------------------------------------------------------
// pn2d_ram: one copy of the permutation table
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module pn2d_ram import pn2d_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [ENTRY_W-1:0]       rd_data_a,
  output logic [ENTRY_W-1:0]       rd_data_b
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, held while the stage stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hw/rtl/pn2d_fade.sv]
// ----------------------------------------------------------------------------
// pn2d_fade: quintic fade curve 6t^5 - 15t^4 + 10t^3 in three stages
// square, cube with the inner quadratic, then the final product
// ----------------------------------------------------------------------------
module pn2d_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [2:0]           stage_en,
  input  logic [FRAC_BITS-1:0] frac_in,
  output logic [FRAC_BITS+2:0] fade_out
);

  localparam int FB = FRAC_BITS;
  localparam int SW = 2 * FB;
  localparam int QW = FB + 4;
  localparam int WW = FB + 3;
  localparam int PW = FB + QW;

  localparam logic [SW-1:0] HALF_S  = SW'(1) << (FB - 1);
  localparam logic [PW-1:0] HALF_P  = PW'(1) << (FB - 1);
  localparam logic [QW-1:0] TEN_ONE = QW'(10) << FB;

  logic [FB-1:0] t2_r, fa_r, t3_r;
  logic [QW-1:0] q_r;
  logic [SW-1:0] sq_rnd, cube_rnd;
  logic [QW-1:0] q_pos, q_neg, q_nxt;
  logic [PW-1:0] prod_rnd;

  // stage a: t^2 rounded
  assign sq_rnd = frac_in * frac_in + HALF_S;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      t2_r <= sq_rnd[SW-1:FB];
      fa_r <= frac_in;
    end
  end

  // stage b: t^3 rounded and 6t^2 - 15t + 10, clamped at zero
  assign cube_rnd = t2_r * fa_r + HALF_S;

  always_comb begin
    q_pos = (QW'(t2_r) << 2) + (QW'(t2_r) << 1) + TEN_ONE;
    q_neg = (QW'(fa_r) << 4) - QW'(fa_r);
    q_nxt = (q_pos >= q_neg) ? q_pos - q_neg : '0;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      t3_r <= cube_rnd[SW-1:FB];
      q_r  <= q_nxt;
    end
  end

  // stage c: t^3 times the quadratic, rounded
  assign prod_rnd = t3_r * q_r + HALF_P;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      fade_out <= prod_rnd[FB +: WW];
    end
  end

endmodule

[hw/rtl/perlin_noise_2d_unit.sv]
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit: 2-D gradient noise in fixed point, loadable permutation
// output: one result per evaluate transaction; loads give none
// throughput: 1 transaction per cycle unless stalled; 5 table copies, 2 reads per cycle
// reset: synchronous rst_n clears the valid bits only; table undefined until loaded
// ----------------------------------------------------------------------------
module perlin_noise_2d_unit import pn2d_pkg::*; #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pn2d_in_if.sink     in_ch,
  pn2d_out_if.source  out_ch
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int FB  = FRAC_BITS;
  localparam int WW  = FB + 3;
  localparam int GW  = FB + 3;
  localparam int DW  = FB + 4;
  localparam int EW  = FB + 5;
  localparam int DEW = FB + 6;
  localparam int PW  = WW + 1 + DEW;
  localparam int RW  = PW - FB + 1;
  localparam int XW  = (EW + 1 > OUT_W) ? EW + 1 : OUT_W;
  localparam int XCW = 2 * COORD_W;

  localparam logic [PW-1:0]        HALF_P = PW'(1) << (FB - 1);
  localparam logic signed [GW-1:0] ONE_G  = GW'(1) << FB;
  localparam logic signed [XW-1:0] SAT_HI = XW'(OUT_MAX);
  localparam logic signed [XW-1:0] SAT_LO = XW'(OUT_MIN);

  // signed round to nearest, ties away from zero, divide by one unit
  function automatic logic signed [RW-1:0] rnds(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] sum;
    mag  = p[PW-1] ? -p : p;
    sum  = mag + HALF_P;
    rnds = p[PW-1] ? -$signed({1'b0, sum[PW-1:FB]}) : $signed({1'b0, sum[PW-1:FB]});
  endfunction

  // corner dot product with a diagonal gradient
  function automatic logic signed [GW-1:0] dot(input logic [1:0] sel,
                                               input logic signed [GW-1:0] dx,
                                               input logic signed [GW-1:0] dy);
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    u   = sel[0] ? -dx : dx;
    v   = sel[1] ? -dy : dy;
    dot = u + v;
  endfunction

  // stage control
  logic [10:1] stage_en;
  logic [9:1]  vld_r;
  logic        out_valid_r;

  // stage payload
  cmd_t                  cmd1_r, cmd2_r, cmd3_r;
  logic [IW-1:0]         idx1_r, idx2_r, idx3_r;
  logic [ENTRY_W-1:0]    val1_r, val2_r, val3_r;
  logic [IW-1:0]         cy1_r, cy2_r;
  logic [FB-1:0]         fx1_r, fy1_r, fx2_r, fy2_r, fx3_r, fy3_r, fx4_r, fy4_r;
  logic [WW-1:0]         wu4, wv4, wu5_r, wv5_r, wv6_r, wv7_r, wv8_r;
  logic signed [GW-1:0]  g00_5_r, g01_5_r, g00_6_r, g01_6_r;
  logic signed [DW-1:0]  d0_5_r, d1_5_r;
  logic signed [PW-1:0]  p0_6_r, p1_6_r, p_9_r;
  logic signed [EW-1:0]  e0_7_r, e1_7_r, e0_8_r, e0_9_r;
  logic signed [DEW-1:0] de_8_r;
  logic signed [OUT_W-1:0] noise_r;

  // table read data
  logic [ENTRY_W-1:0] perm_a0, perm_a1;
  logic [ENTRY_W-1:0] hash_aa, hash_ab, hash_ba, hash_bb;
  logic [ENTRY_W-1:0] grad_aa, grad_ab, grad_ba, grad_bb;

  // combinational helpers
  logic [XCW-1:0]        x_ext, y_ext;
  logic [IW-1:0]         ha, hb;
  logic signed [GW-1:0]  fxs, fys, fx1s, fy1s, g00, g10, g01, g11;
  logic signed [XW-1:0]  res_sum;
  logic signed [OUT_W-1:0] noise_nxt;

  // stall chain: a stage loads when it is empty or its item moves on
  always_comb begin
    stage_en[10] = !out_valid_r || out_ch.ready;
    for (int k = 9; k >= 1; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  assign in_ch.ready        = stage_en[1];
  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = noise_r;

  // valid bits; load transactions leave the pipeline after the last table copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_en[1]) vld_r[1] <= in_ch.valid;
      if (stage_en[2]) vld_r[2] <= vld_r[1];
      if (stage_en[3]) vld_r[3] <= vld_r[2];
      if (stage_en[4]) vld_r[4] <= vld_r[3] && (cmd3_r == CMD_EVAL);
      for (int k = 5; k <= 9; k++) begin
        if (stage_en[k]) vld_r[k] <= vld_r[k-1];
      end
      if (stage_en[10]) out_valid_r <= vld_r[9];
    end
  end

  // stage 1: split coordinates into cell and fraction
  assign x_ext = {{COORD_W{in_ch.x_coord[COORD_W-1]}}, in_ch.x_coord};
  assign y_ext = {{COORD_W{in_ch.y_coord[COORD_W-1]}}, in_ch.y_coord};

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      cmd1_r <= cmd_t'(in_ch.cmd);
      idx1_r <= (in_ch.cmd == CMD_EVAL) ? x_ext[FB +: IW] : IW'(in_ch.table_index);
      val1_r <= in_ch.table_value;
      cy1_r  <= y_ext[FB +: IW];
      fx1_r  <= in_ch.x_coord[FB-1:0];
      fy1_r  <= in_ch.y_coord[FB-1:0];
    end
  end

  // first table level: perm[cx], perm[cx + 1]
  pn2d_ram #(.DEPTH(TABLE_SIZE)) u_ram_a (
    .clk       (clk),
    .wr_en     (vld_r[1] && (cmd1_r == CMD_LOAD) && stage_en[2]),
    .wr_addr   (idx1_r),
    .wr_data   (val1_r),
    .rd_en     (stage_en[2]),
    .rd_addr_a (idx1_r),
    .rd_addr_b (idx1_r + IW'(1)),
    .rd_data_a (perm_a0),
    .rd_data_b (perm_a1)
  );

  // fade curves for both axes run beside the table levels
  pn2d_fade #(.FRAC_BITS(FB)) u_fade_x (
    .clk      (clk),
    .stage_en (stage_en[4:2]),
    .frac_in  (fx1_r),
    .fade_out (wu4)
  );

  pn2d_fade #(.FRAC_BITS(FB)) u_fade_y (
    .clk      (clk),
    .stage_en (stage_en[4:2]),
    .frac_in  (fy1_r),
    .fade_out (wv4)
  );

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      cmd2_r <= cmd1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      cy2_r  <= cy1_r;
      fx2_r  <= fx1_r;
      fy2_r  <= fy1_r;
    end
  end

  // second table level: row hashes
  assign ha = IW'(perm_a0) + cy2_r;
  assign hb = IW'(perm_a1) + cy2_r;

  pn2d_ram #(.DEPTH(TABLE_SIZE)) u_ram_b (
    .clk       (clk),
    .wr_en     (vld_r[2] && (cmd2_r == CMD_LOAD) && stage_en[3]),
    .wr_addr   (idx2_r),
    .wr_data   (val2_r),
    .rd_en     (stage_en[3]),
    .rd_addr_a (ha),
    .rd_addr_b (ha + IW'(1)),
    .rd_data_a (hash_aa),
    .rd_data_b (hash_ab)
  );

  pn2d_ram #(.DEPTH(TABLE_SIZE)) u_ram_c (
    .clk       (clk),
    .wr_en     (vld_r[2] && (cmd2_r == CMD_LOAD) && stage_en[3]),
    .wr_addr   (idx2_r),
    .wr_data   (val2_r),
    .rd_en     (stage_en[3]),
    .rd_addr_a (hb),
    .rd_addr_b (hb + IW'(1)),
    .rd_data_a (hash_ba),
    .rd_data_b (hash_bb)
  );

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      cmd3_r <= cmd2_r;
      idx3_r <= idx2_r;
      val3_r <= val2_r;
      fx3_r  <= fx2_r;
      fy3_r  <= fy2_r;
    end
  end

  // third table level: gradient selectors of the four corners
  pn2d_ram #(.DEPTH(TABLE_SIZE)) u_ram_d (
    .clk       (clk),
    .wr_en     (vld_r[3] && (cmd3_r == CMD_LOAD) && stage_en[4]),
    .wr_addr   (idx3_r),
    .wr_data   (val3_r),
    .rd_en     (stage_en[4]),
    .rd_addr_a (IW'(hash_aa)),
    .rd_addr_b (IW'(hash_ab)),
    .rd_data_a (grad_aa),
    .rd_data_b (grad_ab)
  );

  pn2d_ram #(.DEPTH(TABLE_SIZE)) u_ram_e (
    .clk       (clk),
    .wr_en     (vld_r[3] && (cmd3_r == CMD_LOAD) && stage_en[4]),
    .wr_addr   (idx3_r),
    .wr_data   (val3_r),
    .rd_en     (stage_en[4]),
    .rd_addr_a (IW'(hash_ba)),
    .rd_addr_b (IW'(hash_bb)),
    .rd_data_a (grad_ba),
    .rd_data_b (grad_bb)
  );

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      fx4_r <= fx3_r;
      fy4_r <= fy3_r;
    end
  end

  // stage 5: corner dot products and x-direction differences
  always_comb begin
    fxs  = $signed(GW'(fx4_r));
    fys  = $signed(GW'(fy4_r));
    fx1s = fxs - ONE_G;
    fy1s = fys - ONE_G;
    g00  = dot(grad_aa[1:0], fxs, fys);
    g01  = dot(grad_ab[1:0], fxs, fy1s);
    g10  = dot(grad_ba[1:0], fx1s, fys);
    g11  = dot(grad_bb[1:0], fx1s, fy1s);
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      wu5_r   <= wu4;
      wv5_r   <= wv4;
      g00_5_r <= g00;
      g01_5_r <= g01;
      d0_5_r  <= DW'(g10) - DW'(g00);
      d1_5_r  <= DW'(g11) - DW'(g01);
    end
  end

  // stage 6: weight the x differences
  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      wv6_r   <= wv5_r;
      g00_6_r <= g00_5_r;
      g01_6_r <= g01_5_r;
      p0_6_r  <= PW'($signed({1'b0, wu5_r})) * PW'(d0_5_r);
      p1_6_r  <= PW'($signed({1'b0, wu5_r})) * PW'(d1_5_r);
    end
  end

  // stage 7: finish the two x blends
  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      wv7_r  <= wv6_r;
      e0_7_r <= EW'(g00_6_r) + EW'(rnds(p0_6_r));
      e1_7_r <= EW'(g01_6_r) + EW'(rnds(p1_6_r));
    end
  end

  // stage 8: y difference
  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      wv8_r  <= wv7_r;
      e0_8_r <= e0_7_r;
      de_8_r <= DEW'(e1_7_r) - DEW'(e0_7_r);
    end
  end

  // stage 9: weight the y difference
  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      e0_9_r <= e0_8_r;
      p_9_r  <= PW'($signed({1'b0, wv8_r})) * PW'(de_8_r);
    end
  end

  // output register: final blend and saturation
  always_comb begin
    res_sum = XW'(e0_9_r) + XW'(rnds(p_9_r));
    if (res_sum > SAT_HI) begin
      noise_nxt = OUT_W'(SAT_HI);
    end else if (res_sum < SAT_LO) begin
      noise_nxt = OUT_W'(SAT_LO);
    end else begin
      noise_nxt = OUT_W'(res_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[10]) begin
      noise_r <= noise_nxt;
    end
  end

endmodule

[hw/rtl/pn2d_checker.sv]
// ----------------------------------------------------------------------------
// pn2d_checker: port-level checks for the 2-D gradient noise unit
// tracks evaluate transactions in flight against delivered results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pn2d_checker import pn2d_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_cmd,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_noise_value
);

  logic [4:0] pend_r;
  logic       eval_acc;
  logic       out_acc;

  assign eval_acc = in_valid && in_ready && (in_cmd == CMD_EVAL);
  assign out_acc  = out_valid && out_ready;

  // evaluate transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 5'(eval_acc) - 5'(out_acc);
    end
  end

  `PN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `PN_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_noise_value), "result changed while stalled")
  `PN_ASSERT(a_no_phantom, out_valid |-> pend_r != 5'd0, "result without a pending evaluate")
  `PN_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with output register empty")
  `PN_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind perlin_noise_2d_unit pn2d_checker u_pn2d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_noise_value (out_ch.noise_value)
);
